// ----- rtl/rpf_pkg.sv -----
// Shared types and constants for the plane fitting block.
// No dependencies; rpf_mac, rpf_isqrt and ransac_plane_fit import this package.
package rpf_pkg;

   localparam int COORD_BITS = 16;
   localparam int INDEX_W    = 10;
   localparam int COUNT_W    = 11;
   localparam int TOL_W      = 16;
   localparam int CSR_W      = 16;

   // arithmetic widths of the shared multiply-accumulate path
   localparam int DIFF_W  = COORD_BITS + 1;
   localparam int NORM_W  = 2 * DIFF_W + 1;
   localparam int NSQ_W   = 2 * NORM_W + 1;
   localparam int MUL_W   = (NORM_W + 1 > 2 * TOL_W + 1) ? NORM_W + 1 : 2 * TOL_W + 1;
   localparam int CHUNK_W = MUL_W - 1;
   localparam int ACC_W   = NSQ_W + 2 * TOL_W + 1;
   localparam int ROOT_W  = (ACC_W + 1) / 2;

   localparam logic CSR_POINT_COUNT = 1'b0;
   localparam logic CSR_TOLERANCE   = 1'b1;

   localparam logic [1:0] SHIFT_NONE = 2'd0;
   localparam logic [1:0] SHIFT_ONE  = 2'd1;
   localparam logic [1:0] SHIFT_TWO  = 2'd2;

   typedef enum logic [1:0] {
      KIND_LOAD,
      KIND_CLEAR,
      KIND_TRIAL,
      KIND_READ
   } req_kind_type;

   typedef struct packed {
      req_kind_type                 kind;
      logic [INDEX_W-1:0]           point_index;
      logic signed [COORD_BITS-1:0] coord_x;
      logic signed [COORD_BITS-1:0] coord_y;
      logic signed [COORD_BITS-1:0] coord_z;
      logic [INDEX_W-1:0]           sample_a;
      logic [INDEX_W-1:0]           sample_b;
      logic [INDEX_W-1:0]           sample_c;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] trial_inliers;
      logic [COUNT_W-1:0] best_inliers;
      logic               replaced;
      logic               is_best_inlier;
      logic               bad_request;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic signed [COORD_BITS-1:0] z;
   } point_type;

   typedef struct packed {
      logic       en;
      logic       clr;
      logic       sub;
      logic [1:0] shift;
   } mac_ctrl_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_FETCH,
      ST_CROSS,
      ST_NORM,
      ST_BOUND,
      ST_ROOT,
      ST_SWEEP,
      ST_FINISH
   } state_type;

endpackage

// ----- rtl/rpf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No package dependencies.
module rpf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/rpf_mac.sv -----
// Shared signed multiply-accumulate unit with chunk-aligned shift of the product.
// Depends on rpf_pkg.
module rpf_mac import rpf_pkg::*; (
   input  logic                     clock,
   input  mac_ctrl_type             ctrl,
   input  logic signed [MUL_W-1:0]  op_a,
   input  logic signed [MUL_W-1:0]  op_b,
   output logic signed [ACC_W-1:0]  acc
);

   logic signed [2*MUL_W-1:0] prod;
   logic signed [ACC_W-1:0]   ext;
   logic signed [ACC_W-1:0]   term;
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [ACC_W-1:0]   acc_in;

   always_comb begin
      prod = op_a * op_b;
      ext  = ACC_W'(prod);
      unique case (ctrl.shift)
         SHIFT_NONE: term = ext;
         SHIFT_ONE:  term = ext <<< CHUNK_W;
         default:    term = ext <<< (2 * CHUNK_W);
      endcase
      priority if (ctrl.clr) begin
         acc_in = term;
      end else if (ctrl.sub) begin
         acc_in = acc_ff - term;
      end else begin
         acc_in = acc_ff + term;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.en) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

// ----- rtl/rpf_isqrt.sv -----
// Integer square root, one result bit per cycle (shift and subtract).
// Depends on rpf_pkg.
module rpf_isqrt import rpf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [ACC_W-1:0]  value,
   output logic              done,
   output logic [ROOT_W-1:0] root
);

   localparam int RW    = 2 * ROOT_W;
   localparam int CNT_W = $clog2(ROOT_W + 1);

   logic [RW-1:0]    op_ff;
   logic [RW-1:0]    res_ff;
   logic [RW-1:0]    one_ff;
   logic [RW-1:0]    trial;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;

   assign trial = res_ff + one_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == CNT_W'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         op_ff  <= RW'(value);
         res_ff <= '0;
         one_ff <= RW'(1) << (RW - 2);
         cnt_ff <= CNT_W'(ROOT_W);
      end else if (busy_ff) begin
         if (op_ff >= trial) begin
            op_ff  <= op_ff - trial;
            res_ff <= (res_ff >> 1) + one_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         one_ff <= one_ff >> 2;
         cnt_ff <= cnt_ff - CNT_W'(1);
      end
   end

   assign done = done_ff;
   assign root = res_ff[ROOT_W-1:0];

endmodule

// ----- rtl/ransac_plane_fit.sv -----
// Plane fitting over a loaded point store: the sequencer, stores and result register.
// Depends on rpf_pkg, rpf_ram, rpf_mac and rpf_isqrt.
//
// One request is handled at a time. A load or an out-of-range request is answered
// straight from the idle state; a read goes through ST_READ and ST_FINISH. A clear
// sweeps the best-inlier bitmap, one entry per cycle, then answers from ST_FINISH;
// the same sweep runs after reset, and req_stall stays high during it. In a trial the
// shared multiply-accumulate unit forms the plane residual of each stored point from
// three products, after the point memory read and before the inlier decision, and the
// tolerance bound goes through a bit-serial square root once per trial. The inlier
// test |r| <= floor(sqrt(tol^2 * |n|^2)) is exact in integers.
module ransac_plane_fit import rpf_pkg::*; #(
   parameter int MAX_POINTS = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   input  logic             csr_we,
   input  logic             csr_addr,
   input  logic [CSR_W-1:0] csr_wdata
);

   localparam int AW    = $clog2(MAX_POINTS);
   localparam int CMP_W = 17;

   state_type                   state_ff, state_in;
   logic [2:0]                  ph_ff, ph_in;
   logic [AW-1:0]               i_ff, i_in;
   logic [COUNT_W-1:0]          count_ff, count_in;
   logic [COUNT_W-1:0]          best_count_ff, best_count_in;
   logic                        best_bank_ff, best_bank_in;
   logic                        clr_resp_ff, clr_resp_in;
   logic                        rsp_valid_ff;
   rsp_type                     rsp_ff;
   logic [COUNT_W-1:0]          point_count_ff;
   logic [TOL_W-1:0]            tol_ff;

   req_kind_type                kind_ff;
   logic [INDEX_W-1:0]          idx_ff, a_ff, b_ff, c_ff;
   point_type                   pa_ff, pb_ff, pc_ff;
   logic signed [NORM_W-1:0]    na_ff, nb_ff, nc_ff;
   logic [NSQ_W-1:0]            norm2_ff;
   logic [2*TOL_W-1:0]          tol2_ff;
   logic [ROOT_W-1:0]           root_ff;
   logic                        zero_ff;

   logic                        accept, out_free, put;
   rsp_type                     put_data;
   logic [CMP_W-1:0]            n_eff;
   logic                        idx_in_store, idx_in_range, samples_ok;
   logic                        pt_we;
   logic [AW-1:0]               pt_raddr;
   point_type                   pt_rdata, pt_wdata;
   logic                        bm_we, bm_bank, bm_wdata;
   logic                        bm0_rdata, bm1_rdata, best_flag;
   mac_ctrl_type                mac_ctrl;
   logic signed [MUL_W-1:0]     op_a, op_b;
   logic signed [ACC_W-1:0]     acc;
   logic                        sq_start, sq_done;
   logic [ROOT_W-1:0]           sq_root;
   logic signed [DIFF_W-1:0]    ux, uy, uz, vx, vy, vz, dx, dy, dz;
   logic [3*CHUNK_W-1:0]        n2x;
   logic [ACC_W-1:0]            r_mag;
   logic                        in_range_i, is_sample, inlier, flag;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !(state_ff == ST_IDLE && out_free);
   assign accept    = req_valid && !req_stall;

   assign n_eff = (CMP_W'(point_count_ff) > CMP_W'(MAX_POINTS)) ? CMP_W'(MAX_POINTS)
                                                                : CMP_W'(point_count_ff);
   assign idx_in_store = CMP_W'(req_data.point_index) < CMP_W'(MAX_POINTS);
   assign idx_in_range = CMP_W'(req_data.point_index) < n_eff;
   assign samples_ok   = (CMP_W'(req_data.sample_a) < n_eff)
                      && (CMP_W'(req_data.sample_b) < n_eff)
                      && (CMP_W'(req_data.sample_c) < n_eff);

   assign ux = DIFF_W'(pb_ff.x) - DIFF_W'(pa_ff.x);
   assign uy = DIFF_W'(pb_ff.y) - DIFF_W'(pa_ff.y);
   assign uz = DIFF_W'(pb_ff.z) - DIFF_W'(pa_ff.z);
   assign vx = DIFF_W'(pc_ff.x) - DIFF_W'(pa_ff.x);
   assign vy = DIFF_W'(pc_ff.y) - DIFF_W'(pa_ff.y);
   assign vz = DIFF_W'(pc_ff.z) - DIFF_W'(pa_ff.z);
   assign dx = DIFF_W'(pt_rdata.x) - DIFF_W'(pa_ff.x);
   assign dy = DIFF_W'(pt_rdata.y) - DIFF_W'(pa_ff.y);
   assign dz = DIFF_W'(pt_rdata.z) - DIFF_W'(pa_ff.z);
   assign n2x = (3 * CHUNK_W)'(norm2_ff);

   assign r_mag      = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
   assign in_range_i = CMP_W'(i_ff) < n_eff;
   assign is_sample  = (CMP_W'(i_ff) == CMP_W'(a_ff)) || (CMP_W'(i_ff) == CMP_W'(b_ff))
                    || (CMP_W'(i_ff) == CMP_W'(c_ff));
   assign inlier     = !zero_ff && (r_mag <= ACC_W'(root_ff));
   assign flag       = in_range_i && (is_sample || inlier);
   assign best_flag  = best_bank_ff ? bm1_rdata : bm0_rdata;

   assign pt_wdata = '{x: req_data.coord_x, y: req_data.coord_y, z: req_data.coord_z};

   always_comb begin
      state_in      = state_ff;
      ph_in         = ph_ff;
      i_in          = i_ff;
      count_in      = count_ff;
      best_count_in = best_count_ff;
      best_bank_in  = best_bank_ff;
      clr_resp_in   = clr_resp_ff;
      put           = 1'b0;
      put_data      = '0;
      pt_we         = 1'b0;
      pt_raddr      = AW'(a_ff);
      bm_we         = 1'b0;
      bm_bank       = best_bank_ff;
      bm_wdata      = 1'b0;
      mac_ctrl      = '0;
      op_a          = '0;
      op_b          = '0;
      sq_start      = 1'b0;
      put_data.best_inliers = best_count_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            bm_we = 1'b1;
            i_in  = i_ff + AW'(1);
            if (i_ff == AW'(MAX_POINTS - 1)) begin
               i_in     = '0;
               state_in = clr_resp_ff ? ST_FINISH : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (req_data.kind)
                  KIND_LOAD: begin
                     pt_we                 = idx_in_store;
                     put                   = 1'b1;
                     put_data.bad_request  = !idx_in_store;
                  end
                  KIND_CLEAR: begin
                     best_count_in = '0;
                     i_in          = '0;
                     clr_resp_in   = 1'b1;
                     state_in      = ST_CLEAR;
                  end
                  KIND_TRIAL: begin
                     if (samples_ok) begin
                        ph_in    = '0;
                        state_in = ST_FETCH;
                     end else begin
                        put                  = 1'b1;
                        put_data.bad_request = 1'b1;
                     end
                  end
                  default: begin
                     if (idx_in_range) begin
                        state_in = ST_READ;
                     end else begin
                        put                  = 1'b1;
                        put_data.bad_request = 1'b1;
                     end
                  end
               endcase
            end
         end
         ST_READ: begin
            state_in = ST_FINISH;
         end
         ST_FETCH: begin
            unique case (ph_ff)
               3'd0:    pt_raddr = AW'(a_ff);
               3'd1:    pt_raddr = AW'(b_ff);
               default: pt_raddr = AW'(c_ff);
            endcase
            ph_in = ph_ff + 3'd1;
            if (ph_ff == 3'd3) begin
               ph_in    = '0;
               state_in = ST_CROSS;
            end
         end
         ST_CROSS: begin
            mac_ctrl.en  = 1'b1;
            mac_ctrl.clr = !ph_ff[0];
            mac_ctrl.sub = ph_ff[0];
            unique case (ph_ff)
               3'd0: begin op_a = MUL_W'(uy); op_b = MUL_W'(vz); end
               3'd1: begin op_a = MUL_W'(uz); op_b = MUL_W'(vy); end
               3'd2: begin op_a = MUL_W'(uz); op_b = MUL_W'(vx); end
               3'd3: begin op_a = MUL_W'(ux); op_b = MUL_W'(vz); end
               3'd4: begin op_a = MUL_W'(ux); op_b = MUL_W'(vy); end
               default: begin op_a = MUL_W'(uy); op_b = MUL_W'(vx); end
            endcase
            ph_in = ph_ff + 3'd1;
            if (ph_ff == 3'd5) begin
               ph_in    = '0;
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            mac_ctrl.en  = 1'b1;
            mac_ctrl.clr = (ph_ff == 3'd0);
            unique case (ph_ff)
               3'd0:    begin op_a = MUL_W'(na_ff); op_b = MUL_W'(na_ff); end
               3'd1:    begin op_a = MUL_W'(nb_ff); op_b = MUL_W'(nb_ff); end
               default: begin op_a = MUL_W'(nc_ff); op_b = MUL_W'(nc_ff); end
            endcase
            ph_in = ph_ff + 3'd1;
            if (ph_ff == 3'd2) begin
               ph_in    = '0;
               state_in = ST_BOUND;
            end
         end
         ST_BOUND: begin
            op_a = MUL_W'($signed({1'b0, tol2_ff}));
            unique case (ph_ff)
               3'd0: begin
                  mac_ctrl.en  = 1'b1;
                  mac_ctrl.clr = 1'b1;
                  op_a         = MUL_W'($signed({1'b0, tol_ff}));
                  op_b         = MUL_W'($signed({1'b0, tol_ff}));
               end
               3'd1: begin
               end
               3'd2: begin
                  mac_ctrl.en  = 1'b1;
                  mac_ctrl.clr = 1'b1;
                  op_b = $signed({1'b0, n2x[CHUNK_W-1:0]});
               end
               3'd3: begin
                  mac_ctrl.en    = 1'b1;
                  mac_ctrl.shift = SHIFT_ONE;
                  op_b = $signed({1'b0, n2x[2*CHUNK_W-1:CHUNK_W]});
               end
               default: begin
                  mac_ctrl.en    = 1'b1;
                  mac_ctrl.shift = SHIFT_TWO;
                  op_b = $signed({1'b0, n2x[3*CHUNK_W-1:2*CHUNK_W]});
               end
            endcase
            ph_in = ph_ff + 3'd1;
            if (ph_ff == 3'd4) begin
               ph_in    = '0;
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (ph_ff == 3'd0) begin
               sq_start = 1'b1;
               ph_in    = 3'd1;
            end else if (sq_done) begin
               ph_in    = '0;
               i_in     = '0;
               count_in = '0;
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            pt_raddr     = i_ff;
            mac_ctrl.clr = (ph_ff == 3'd1);
            mac_ctrl.en  = (ph_ff != 3'd0) && (ph_ff != 3'd4);
            unique case (ph_ff)
               3'd1:    begin op_a = MUL_W'(na_ff); op_b = MUL_W'(dx); end
               3'd2:    begin op_a = MUL_W'(nb_ff); op_b = MUL_W'(dy); end
               default: begin op_a = MUL_W'(nc_ff); op_b = MUL_W'(dz); end
            endcase
            ph_in = ph_ff + 3'd1;
            if (ph_ff == 3'd4) begin
               // decide this point and write it into the scratch bank
               bm_we    = 1'b1;
               bm_bank  = !best_bank_ff;
               bm_wdata = flag;
               count_in = count_ff + COUNT_W'(flag);
               ph_in    = '0;
               i_in     = i_ff + AW'(1);
               if (i_ff == AW'(MAX_POINTS - 1)) begin
                  i_in     = '0;
                  state_in = ST_FINISH;
               end
            end
         end
         default: begin
            // ST_FINISH: hold until the result register is free
            if (out_free) begin
               put         = 1'b1;
               clr_resp_in = 1'b0;
               state_in    = ST_IDLE;
               if (kind_ff == KIND_TRIAL) begin
                  put_data.trial_inliers = count_ff;
                  if (count_ff > best_count_ff) begin
                     best_count_in         = count_ff;
                     best_bank_in          = !best_bank_ff;
                     put_data.best_inliers = count_ff;
                     put_data.replaced     = 1'b1;
                  end
               end else if (kind_ff == KIND_READ) begin
                  put_data.is_best_inlier = best_flag;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         ph_ff          <= '0;
         i_ff           <= '0;
         count_ff       <= '0;
         best_count_ff  <= '0;
         best_bank_ff   <= 1'b0;
         clr_resp_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         point_count_ff <= COUNT_W'(1024);
         tol_ff         <= TOL_W'(1);
      end else begin
         state_ff      <= state_in;
         ph_ff         <= ph_in;
         i_ff          <= i_in;
         count_ff      <= count_in;
         best_count_ff <= best_count_in;
         best_bank_ff  <= best_bank_in;
         clr_resp_ff   <= clr_resp_in;
         rsp_valid_ff  <= put || (rsp_valid_ff && rsp_stall);
         if (csr_we) begin
            unique case (csr_addr)
               CSR_POINT_COUNT: point_count_ff <= csr_wdata[COUNT_W-1:0];
               default:         tol_ff         <= csr_wdata[TOL_W-1:0];
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (put) begin
         rsp_ff <= put_data;
      end
      if (accept) begin
         kind_ff <= req_data.kind;
         idx_ff  <= req_data.point_index;
         a_ff    <= req_data.sample_a;
         b_ff    <= req_data.sample_b;
         c_ff    <= req_data.sample_c;
      end
      if (state_ff == ST_FETCH) begin
         if (ph_ff == 3'd1) pa_ff <= pt_rdata;
         if (ph_ff == 3'd2) pb_ff <= pt_rdata;
         if (ph_ff == 3'd3) pc_ff <= pt_rdata;
      end
      if (state_ff == ST_CROSS && ph_ff == 3'd2) na_ff <= acc[NORM_W-1:0];
      if (state_ff == ST_CROSS && ph_ff == 3'd4) nb_ff <= acc[NORM_W-1:0];
      if (state_ff == ST_NORM && ph_ff == 3'd0) nc_ff <= acc[NORM_W-1:0];
      if (state_ff == ST_BOUND && ph_ff == 3'd0) begin
         norm2_ff <= acc[NSQ_W-1:0];
         zero_ff  <= (na_ff == '0) && (nb_ff == '0) && (nc_ff == '0);
      end
      if (state_ff == ST_BOUND && ph_ff == 3'd1) tol2_ff <= acc[2*TOL_W-1:0];
      if (sq_done) root_ff <= sq_root;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   rpf_ram #(.WIDTH($bits(point_type)), .DEPTH(MAX_POINTS)) u_point_ram (
      .clock (clock),
      .we    (pt_we),
      .waddr (AW'(req_data.point_index)),
      .wdata (pt_wdata),
      .raddr (pt_raddr),
      .rdata (pt_rdata)
   );

   rpf_ram #(.WIDTH(1), .DEPTH(MAX_POINTS)) u_bitmap0 (
      .clock (clock),
      .we    (bm_we && !bm_bank),
      .waddr (i_ff),
      .wdata (bm_wdata),
      .raddr (AW'(idx_ff)),
      .rdata (bm0_rdata)
   );

   rpf_ram #(.WIDTH(1), .DEPTH(MAX_POINTS)) u_bitmap1 (
      .clock (clock),
      .we    (bm_we && bm_bank),
      .waddr (i_ff),
      .wdata (bm_wdata),
      .raddr (AW'(idx_ff)),
      .rdata (bm1_rdata)
   );

   rpf_mac u_mac (
      .clock (clock),
      .ctrl  (mac_ctrl),
      .op_a  (op_a),
      .op_b  (op_b),
      .acc   (acc)
   );

   rpf_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (sq_start),
      .value (ACC_W'(acc)),
      .done  (sq_done),
      .root  (sq_root)
   );

endmodule
